@@ src/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/btpd_pkg.sv @@
// ---------------------------------------------------------------------------
// btpd_pkg
// Types, constants and tables of the tilt balance controller.
// ---------------------------------------------------------------------------
package btpd_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int DUTY_BITS    = 10;
	localparam int TABLE_LEN    = 24;
	localparam int STEP_CNT_W   = 5;

	localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
	localparam logic signed [39:0] HALF_PI_U20 = 40'sd1647100;
	localparam logic [2:0] REG_TAU = 3'd0;
	localparam logic [2:0] REG_CNEW = 3'd1;
	localparam logic [2:0] REG_COLD = 3'd2;
	localparam logic [2:0] REG_KP = 3'd3;
	localparam logic [2:0] REG_KD = 3'd4;
	localparam logic [2:0] REG_FRIC = 3'd5;
	localparam logic [2:0] REG_TGT = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_CORDIC, ST_ROUND, ST_LP_G1, ST_LP_G2, ST_LP_W1, ST_LP_W2,
		ST_TILT, ST_CMD1, ST_CMD2, ST_CMD3, ST_DUTY, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ITER, OP_ROUND, OP_LPG1, OP_LPG2, OP_LPW1, OP_LPW2,
		OP_TILT, OP_CMD1, OP_CMD2, OP_CMD3, OP_DUTY
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [STEP_CNT_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic [9:0]         tau_ms;
		logic [15:0]        coef_new;
		logic [15:0]        coef_old;
		logic [15:0]        gain_p;
		logic [15:0]        gain_d;
		logic [11:0]        friction_offset;
		logic signed [15:0] target_angle;
	} cfg_t;

	function automatic logic signed [39:0] atan_entry(input logic [STEP_CNT_W-1:0] i);
		logic signed [39:0] r;
		unique case (i)
			5'd0: r = 40'sd823550;  5'd1: r = 40'sd486170;  5'd2: r = 40'sd256879;
			5'd3: r = 40'sd130396;  5'd4: r = 40'sd65451;   5'd5: r = 40'sd32757;
			5'd6: r = 40'sd16383;   5'd7: r = 40'sd8192;    5'd8: r = 40'sd4096;
			5'd9: r = 40'sd2048;    5'd10: r = 40'sd1024;   5'd11: r = 40'sd512;
			5'd12: r = 40'sd256;    5'd13: r = 40'sd128;    5'd14: r = 40'sd64;
			5'd15: r = 40'sd32;     5'd16: r = 40'sd16;     5'd17: r = 40'sd8;
			5'd18: r = 40'sd4;      5'd19: r = 40'sd2;      5'd20: r = 40'sd1;
			5'd21: r = 40'sd1;
			default: r = 40'sd0;
		endcase
		return r;
	endfunction
endpackage

@@ src/btpd_if.sv @@
// ---------------------------------------------------------------------------
// btpd_in_if / btpd_out_if
// Valid/ready channels for IMU samples and motor results.
// ---------------------------------------------------------------------------
interface btpd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] gyro_rate;
	modport source (output valid, accel_x, accel_y, gyro_rate, input ready);
	modport sink (input valid, accel_x, accel_y, gyro_rate, output ready);
endinterface

interface btpd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tilt_estimate;
	logic signed [12:0] drive_command;
	logic [9:0]         duty_a;
	logic [9:0]         duty_b;
	modport source (output valid, tilt_estimate, drive_command, duty_a, duty_b, input ready);
	modport sink (input valid, tilt_estimate, drive_command, duty_a, duty_b, output ready);
endinterface

@@ src/btpd_ctrl.sv @@
// ---------------------------------------------------------------------------
// btpd_ctrl
// Sequencer: issues the datapath operations for one sample at a time.
// ---------------------------------------------------------------------------
module btpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output btpd_pkg::dp_cmd_t cmd
);
	import btpd_pkg::*;

	state_t                state_q, state_d;
	logic [STEP_CNT_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.op    = OP_NONE;
		cmd.step  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				step_d  = '0;
				state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				cmd.op = OP_ITER;
				step_d = step_q + 1'b1;
				if (step_q == STEP_CNT_W'(CORDIC_STEPS - 1)) state_d = ST_ROUND;
			end
			ST_ROUND: begin cmd.op = OP_ROUND; state_d = ST_LP_G1; end
			ST_LP_G1: begin cmd.op = OP_LPG1; state_d = ST_LP_G2; end
			ST_LP_G2: begin cmd.op = OP_LPG2; state_d = ST_LP_W1; end
			ST_LP_W1: begin cmd.op = OP_LPW1; state_d = ST_LP_W2; end
			ST_LP_W2: begin cmd.op = OP_LPW2; state_d = ST_TILT; end
			ST_TILT:  begin cmd.op = OP_TILT; state_d = ST_CMD1; end
			ST_CMD1:  begin cmd.op = OP_CMD1; state_d = ST_CMD2; end
			ST_CMD2:  begin cmd.op = OP_CMD2; state_d = ST_CMD3; end
			ST_CMD3:  begin cmd.op = OP_CMD3; state_d = ST_DUTY; end
			ST_DUTY:  begin cmd.op = OP_DUTY; state_d = ST_OUT; end
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.op  = OP_LOAD;
						state_d = ST_PREP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

@@ src/btpd_dp.sv @@
// ---------------------------------------------------------------------------
// btpd_dp
// Datapath: CORDIC, gyro scaling, low-pass filters, PD law and duties.
// ---------------------------------------------------------------------------
module btpd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  btpd_pkg::dp_cmd_t  cmd,
	input  btpd_pkg::cfg_t     cfg,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] gyro_rate,
	output logic signed [15:0] tilt_estimate,
	output logic signed [12:0] drive_command,
	output logic [btpd_pkg::DUTY_BITS-1:0] duty_a,
	output logic [btpd_pkg::DUTY_BITS-1:0] duty_b
);
	import btpd_pkg::*;

	logic signed [39:0] x_q, y_q, z_q;
	logic               zero_q;
	logic signed [27:0] prod_w_q;
	logic signed [15:0] theta_g_q;
	logic signed [16:0] theta_w_q;
	logic signed [23:0] filt_g_q, filt_w_q;
	logic signed [51:0] acc_q;
	logic signed [15:0] tilt_q;
	logic signed [40:0] c20_q;
	logic signed [12:0] cmd_q;
	logic [DUTY_BITS-1:0] da_q, db_q;

	logic signed [39:0] xs, ys, xp, yp, zp;
	logic signed [51:0] lp_rnd;
	logic signed [25:0] tsum;
	logic signed [17:0] tr;
	logic signed [40:0] crnd;
	logic signed [33:0] cr;
	logic signed [16:0] err;
	logic [27:0]        wabs;
	logic [27:0]        wq;
	logic signed [28:0] wneg;
	logic signed [13:0] base;
	logic [DUTY_BITS+12:0] pa, pb;

	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign lp_rnd = (acc_q + 52'sd32768) >>> 16;
	assign tsum = 26'(filt_g_q) + 26'(filt_w_q);
	assign tr = 18'((tsum + 26'sd128) >>> 8);
	assign crnd = (c20_q + 41'sd128) >>> 8;
	assign cr = 34'(crnd);
	assign err = 17'(cfg.target_angle) - 17'(tilt_q);
	// |tau*rate| / 1000 by reciprocal: q = (a*1099511628) >> 40, exact for a < 2^26
	assign wabs = prod_w_q[27] ? 28'(-prod_w_q) : 28'(prod_w_q);
	assign base = 14'sd2048 + 14'(cmd_q);
	assign pa = (DUTY_BITS+13)'(DUTY_MAX) * (DUTY_BITS+13)'(unsigned'(base));
	assign pb = (DUTY_BITS+13)'(DUTY_MAX) * (DUTY_BITS+13)'(unsigned'(14'sd4096 - base));

	always_comb begin
		xp = x_q; yp = y_q; zp = z_q;
		if (y_q > 0) begin
			xp = x_q + ys; yp = y_q - xs; zp = z_q + atan_entry(cmd.step);
		end else begin
			xp = x_q - ys; yp = y_q + xs; zp = z_q - atan_entry(cmd.step);
		end
	end

	logic [66:0] recip_prod;
	assign recip_prod = 67'(wabs) * 67'(39'd1099511628);
	assign wq = 28'(recip_prod >> 40);
	assign wneg = prod_w_q[27] ? 29'(wq) : -29'(wq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_g_q <= '0;
			filt_w_q <= '0;
		end else begin
			if (cmd.op == OP_LPG2)
				filt_g_q <= (lp_rnd > 52'sd8388607) ? 24'sd8388607 :
					(lp_rnd < -52'sd8388608) ? -24'sd8388608 : 24'(lp_rnd);
			if (cmd.op == OP_LPW2)
				filt_w_q <= (lp_rnd > 52'sd8388607) ? 24'sd8388607 :
					(lp_rnd < -52'sd8388608) ? -24'sd8388608 : 24'(lp_rnd);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				zero_q <= (accel_x == 16'sd0) && (accel_y == 16'sd0);
				if (accel_x < 0) begin
					if (accel_y >= 0) begin
						x_q <= 40'(accel_y) <<< 14;
						y_q <= -(40'(accel_x) <<< 14);
						z_q <= HALF_PI_U20;
					end else begin
						x_q <= -(40'(accel_y) <<< 14);
						y_q <= 40'(accel_x) <<< 14;
						z_q <= -HALF_PI_U20;
					end
				end else begin
					x_q <= 40'(accel_x) <<< 14;
					y_q <= 40'(accel_y) <<< 14;
					z_q <= '0;
				end
				prod_w_q <= 28'($signed({1'b0, cfg.tau_ms})) * 28'(gyro_rate);
			end
			OP_ITER: begin
				x_q <= xp; y_q <= yp; z_q <= zp;
			end
			OP_ROUND: begin
				theta_g_q <= zero_q ? 16'sd0 : 16'((z_q + 40'sd128) >>> 8);
				theta_w_q <= 17'(wneg);
			end
			OP_LPG1: acc_q <= 52'($signed({1'b0, cfg.coef_new})) * 52'(theta_g_q) * 52'sd256
				+ 52'($signed({1'b0, cfg.coef_old})) * 52'(filt_g_q);
			OP_LPW1: acc_q <= 52'($signed({1'b0, cfg.coef_new})) * 52'(theta_w_q) * 52'sd256
				+ 52'($signed({1'b0, cfg.coef_old})) * 52'(filt_w_q);
			OP_TILT: tilt_q <= (tr > 18'sd32767) ? 16'sd32767 :
				(tr < -18'sd32768) ? -16'sd32768 : 16'(tr);
			OP_CMD1: c20_q <= 41'($signed({1'b0, cfg.gain_p})) * 41'(err);
			OP_CMD2: c20_q <= c20_q - 41'($signed({1'b0, cfg.gain_d})) * 41'(theta_w_q);
			OP_CMD3: begin
				logic signed [33:0] cf;
				cf = cr;
				if (c20_q > 0) cf = cr + 34'(cfg.friction_offset);
				else if (c20_q < 0) cf = cr - 34'(cfg.friction_offset);
				cmd_q <= (cf > 34'sd2048) ? 13'sd2048 :
					(cf < -34'sd2048) ? -13'sd2048 : 13'(cf);
			end
			OP_DUTY: begin
				da_q <= pa[DUTY_BITS+11:12];
				db_q <= pb[DUTY_BITS+11:12];
			end
			default: ;
		endcase
	end

	assign tilt_estimate = tilt_q;
	assign drive_command = cmd_q;
	assign duty_a = da_q;
	assign duty_b = db_q;
endmodule

@@ src/balance_tilt_pd_controller_core.sv @@
// ---------------------------------------------------------------------------
// balance_tilt_pd_controller_core
// Tilt balance controller: CORDIC tilt, complementary filter, PD drive.
// ---------------------------------------------------------------------------
// channel  dir  payload
// smp      in   accel_x, accel_y, gyro_rate
// res      out  tilt_estimate, drive_command, duty_a, duty_b
// cfg      apb  registers 0..6 at 4*i
// The earliest result transfer follows its sample's transfer through these steps:
// prep, 16 CORDIC steps, 10 datapath ops, then the output state.
// The CORDIC iteration loop runs on a single shift-add unit.
// A new sample is taken in the cycle its predecessor's result is transferred,
// so one sample is processed at a time; a stalled result holds off input.
// Reset clears the filter state and the sequencer and loads the register defaults.
module balance_tilt_pd_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	btpd_in_if.sink     smp,
	btpd_out_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import btpd_pkg::*;
	`include "assert_macros.svh"

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	logic    wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr  = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tau_ms          <= 10'd100;
			cfg_q.coef_new        <= 16'd5958;
			cfg_q.coef_old        <= 16'd59578;
			cfg_q.gain_p          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.friction_offset <= '0;
			cfg_q.target_angle    <= 16'sd41;
		end else if (wr) begin
			unique case (idx)
				REG_TAU:  cfg_q.tau_ms <= pwdata[9:0];
				REG_CNEW: cfg_q.coef_new <= pwdata[15:0];
				REG_COLD: cfg_q.coef_old <= pwdata[15:0];
				REG_KP:   cfg_q.gain_p <= pwdata[15:0];
				REG_KD:   cfg_q.gain_d <= pwdata[15:0];
				REG_FRIC: cfg_q.friction_offset <= pwdata[11:0];
				REG_TGT:  cfg_q.target_angle <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TAU:  prdata = 32'(cfg_q.tau_ms);
			REG_CNEW: prdata = 32'(cfg_q.coef_new);
			REG_COLD: prdata = 32'(cfg_q.coef_old);
			REG_KP:   prdata = 32'(cfg_q.gain_p);
			REG_KD:   prdata = 32'(cfg_q.gain_d);
			REG_FRIC: prdata = 32'(cfg_q.friction_offset);
			REG_TGT:  prdata = 32'(cfg_q.target_angle);
			default:  prdata = '0;
		endcase
	end

	btpd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (smp.valid), .in_ready (smp.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.cmd
	);

	btpd_dp u_dp (
		.clk, .arst_n, .cmd, .cfg(cfg_q),
		.accel_x(smp.accel_x), .accel_y(smp.accel_y), .gyro_rate(smp.gyro_rate),
		.tilt_estimate(res.tilt_estimate), .drive_command(res.drive_command),
		.duty_a(res.duty_a), .duty_b(res.duty_b)
	);

	`ASSERT_NEXT(a_load_then_busy, clk, arst_n, smp.valid && smp.ready, !smp.ready, "busy after transfer")
	`ASSERT_IMPL(a_cmd_range, clk, arst_n, res.valid, res.drive_command <= 13'sd2048 && res.drive_command >= -13'sd2048, "command out of range")
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res.valid && !res.ready, res.valid && $stable(res.duty_a), "result dropped")
endmodule

@@ tb/btpd_tb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_tb_pkg
// Register addresses of the tilt balance controller, as the bench uses them.
// ---------------------------------------------------------------------------
package btpd_tb_pkg;
	import btpd_pkg::*;

	function automatic logic [4:0] reg_addr(input logic [2:0] idx);
		return {idx, 2'b00};
	endfunction
endpackage

@@ tb/balance_tilt_pd_controller_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// balance_tilt_pd_controller_core_test
// Drives IMU samples through the controller under several register settings
// and idling patterns. Every result is checked field by field against an
// in-bench fixed-point predictor of the CORDIC tilt, filters and PD command.
// ---------------------------------------------------------------------------
module balance_tilt_pd_controller_core_test;
	import btpd_pkg::*;
	import btpd_tb_pkg::*;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] rate;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] tilt;
		logic signed [12:0] cmd;
		logic [9:0]         da;
		logic [9:0]         db;
	} motor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	btpd_in_if  smp ();
	btpd_out_if res ();

	balance_tilt_pd_controller_core u_dut (
		.clk(clk), .arst_n(arst_n), .smp(smp.sink), .res(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	cfg_t          cfg;
	longint        grav_filt, gyro_filt;
	sample_t       pending_samples[$];
	motor_t        expected_motor[$];
	int            errors = 0;
	int            send_idle = 0, recv_stall = 0;

	initial begin
		smp.valid = 1'b0;
		smp.accel_x = '0;
		smp.accel_y = '0;
		smp.gyro_rate = '0;
		res.ready = 1'b0;
	end

	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint cordic_angle(input longint x, input longint y);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_U20;
			end else begin
				x = -y; y = t; z = -HALF_PI_U20;
			end
		end
		x = x * 16384;
		y = y * 16384;
		for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += atan_entry(i[4:0]);
			end else begin
				x -= ys; y += xs; z -= atan_entry(i[4:0]);
			end
		end
		return rnd_shift(z, 8);
	endfunction

	function automatic longint lowpass(input longint ang, input longint prev);
		longint acc;
		acc = longint'(cfg.coef_new) * (ang * 256) + longint'(cfg.coef_old) * prev;
		return clip(rnd_shift(acc, 16), -8388608, 8388607);
	endfunction

	function automatic motor_t predict_motor(input sample_t s);
		longint th_g, th_w, tilt, c20, cmd, base;
		motor_t m;
		th_g = cordic_angle(s.ax, s.ay);
		th_w = -((longint'(cfg.tau_ms) * longint'(s.rate)) / 1000);
		grav_filt = lowpass(th_g, grav_filt);
		gyro_filt = lowpass(th_w, gyro_filt);
		tilt = clip(rnd_shift(grav_filt + gyro_filt, 8), -32768, 32767);
		c20 = longint'(cfg.gain_p) * (longint'(cfg.target_angle) - tilt)
			- longint'(cfg.gain_d) * th_w;
		cmd = rnd_shift(c20, 8);
		if (c20 > 0) cmd += cfg.friction_offset;
		else if (c20 < 0) cmd -= cfg.friction_offset;
		cmd = clip(cmd, -2048, 2048);
		base = 2048 + cmd;
		m.tilt = tilt[15:0];
		m.cmd = cmd[12:0];
		m.da = 10'((longint'(DUTY_MAX) * base) >>> 12);
		m.db = 10'((longint'(DUTY_MAX) * (4096 - base)) >>> 12);
		return m;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// sample driver and result back-pressure
	always @(posedge clk) begin
		sample_t s;
		if (!smp.valid || smp.ready) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
				s = pending_samples.pop_front();
				smp.valid <= 1'b1;
				smp.accel_x <= s.ax;
				smp.accel_y <= s.ay;
				smp.gyro_rate <= s.rate;
				expected_motor.push_back(predict_motor(s));
			end else begin
				smp.valid <= 1'b0;
			end
		end
		res.ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	// result monitor
	always @(posedge clk) begin
		motor_t w;
		if (arst_n && res.valid && res.ready) begin
			if (expected_motor.size() == 0) begin
				$display("unexpected result transfer");
				errors++;
			end else begin
				w = expected_motor.pop_front();
				if (res.tilt_estimate !== w.tilt)
					report_mismatch("tilt_estimate", res.tilt_estimate, w.tilt);
				if (res.drive_command !== w.cmd)
					report_mismatch("drive_command", res.drive_command, w.cmd);
				if (res.duty_a !== w.da) report_mismatch("duty_a", res.duty_a, w.da);
				if (res.duty_b !== w.db) report_mismatch("duty_b", res.duty_b, w.db);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= reg_addr(idx); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_TAU:  cfg.tau_ms = v[9:0];
			REG_CNEW: cfg.coef_new = v[15:0];
			REG_COLD: cfg.coef_old = v[15:0];
			REG_KP:   cfg.gain_p = v[15:0];
			REG_KD:   cfg.gain_d = v[15:0];
			REG_FRIC: cfg.friction_offset = v[11:0];
			REG_TGT:  cfg.target_angle = v[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || expected_motor.size() > 0 || smp.valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_random(input int n);
		sample_t s;
		for (int i = 0; i < n; i++) begin
			s.ax = rand_field();
			s.ay = rand_field();
			s.rate = $urandom_range(3) == 0 ? rand_field() : 16'($urandom_range(4000)) - 16'd2000;
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		cfg.tau_ms = 100; cfg.coef_new = 5958; cfg.coef_old = 59578;
		cfg.gain_p = 0; cfg.gain_d = 0; cfg.friction_offset = 0;
		cfg.target_angle = 41;
		grav_filt = 0; gyro_filt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// reset-value run
		pending_samples.push_back({16'sd100, 16'sd0, 16'sd0});
		drain();
		write_reg(REG_KP, 32'd800);
		write_reg(REG_KD, 32'd300);
		write_reg(REG_FRIC, 32'd60);
		write_reg(REG_TGT, 32'hFFFF_FF00);
		// zero vector, negative X both halves, extremes
		pending_samples.push_back({16'sd0, 16'sd0, 16'sd0});
		pending_samples.push_back({-16'sd1000, 16'sd1, 16'sd100});
		pending_samples.push_back({-16'sd1000, -16'sd1, -16'sd100});
		pending_samples.push_back({-16'sd1000, 16'sd0, 16'sd0});
		pending_samples.push_back({16'sh8000, 16'sh8000, 16'sh8000});
		pending_samples.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_samples.push_back({16'sh8000, 16'sh7FFF, 16'sh7FFF});
		pending_samples.push_back({16'sd0, 16'sh7FFF, 16'sd0});
		pending_samples.push_back({16'sd0, 16'sh8000, 16'sd0});
		pending_samples.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
		drain();
		// coefficient sum above one, full-scale registers, extreme gains
		write_reg(REG_CNEW, 32'hFFFF);
		write_reg(REG_COLD, 32'hFFFF);
		write_reg(REG_TAU, 32'd1023);
		write_reg(REG_FRIC, 32'hFFF);
		write_reg(REG_KP, 32'hFFFF);
		write_reg(REG_KD, 32'hFFFF);
		write_reg(REG_TGT, 32'h7FFF);
		add_random(10);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 81; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 81; end
				default: begin send_idle = 27; recv_stall = 27; end
			endcase
			write_reg(REG_TAU, $urandom_range(1023));
			write_reg(REG_CNEW, ph == 0 ? 32'd0 : $urandom_range(65535));
			write_reg(REG_COLD, ph == 0 ? 32'd0 : $urandom_range(65535));
			write_reg(REG_KP, $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(2000));
			write_reg(REG_KD, $urandom_range(2000));
			write_reg(REG_FRIC, ph == 1 ? 32'd2048 : $urandom_range(300));
			write_reg(REG_TGT, ph == 2 ? 32'h8000 : $urandom_range(65535));
			add_random(300);
			drain();
		end
		if (errors == 0)
			$display("balance_tilt_pd_controller_core test passed");
		else
			$display("balance_tilt_pd_controller_core test failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("balance_tilt_pd_controller_core test failed");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/btpd_pkg.sv
src/btpd_if.sv
src/btpd_ctrl.sv
src/btpd_dp.sv
src/balance_tilt_pd_controller_core.sv
tb/btpd_tb_pkg.sv
tb/balance_tilt_pd_controller_core_test.sv
